// ----- rtl/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg
// shared types and constants of the hierarchical timer wheel
// ----------------------------------------------------------------------------
`default_nettype none

package htw_pkg;

   localparam int TIME_W      = 64;
   localparam int DELAY_W     = 32;
   localparam int TAG_W       = 16;
   localparam int HANDLE_W    = 6;
   localparam int OP_W        = 2;
   localparam int KIND_W      = 2;
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 2'd0,
      OP_CANCEL  = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED    = 2'd0,
      KIND_FIRED    = 2'd1,
      KIND_REJECTED = 2'd2,
      KIND_DONE     = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_LNK_RD,
      ST_LNK_WR,
      ST_ADV_INIT,
      ST_CAS_SETUP,
      ST_CAS_SLOT,
      ST_CAS_HEAD,
      ST_CH_RD,
      ST_CH_SUB,
      ST_CH_DEC,
      ST_NR_SETUP,
      ST_NR_SLOT,
      ST_NR_HEAD,
      ST_NR_RD,
      ST_NR_CHK,
      ST_NR_REL,
      ST_NR_EMIT,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/htw_req_if.sv -----
// ----------------------------------------------------------------------------
// htw_req_if
// request channel of the timer wheel: operation, time, delay, tag, handle
// ----------------------------------------------------------------------------
`default_nettype none

interface htw_req_if
   import htw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [TIME_W-1:0]   now_ms;
   logic [DELAY_W-1:0]  delay_ms;
   logic [TAG_W-1:0]    user_tag;
   logic [HANDLE_W-1:0] cancel_handle;

   modport source (output valid, op, now_ms, delay_ms, user_tag, cancel_handle,
                   input ready);
   modport sink (input valid, op, now_ms, delay_ms, user_tag, cancel_handle,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/htw_rsp_if.sv -----
// ----------------------------------------------------------------------------
// htw_rsp_if
// response channel of the timer wheel: kind, handle, tag, last marker
// ----------------------------------------------------------------------------
`default_nettype none

interface htw_rsp_if
   import htw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [HANDLE_W-1:0] handle;
   logic [TAG_W-1:0]    fired_tag;
   logic                last;

   modport source (output valid, kind, handle, fired_tag, last, input ready);
   modport sink (input valid, kind, handle, fired_tag, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/hierarchical_timer_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// five-level timing wheel over a fixed entry pool, run by one sequencer
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot and pool memories and holds
// req.ready low. It then takes one transaction at a time. An add reads the
// free list, writes the entry and links it into its slot; a cancel or a
// rejected add goes straight to its response, and all wait for the response
// slot. An advance walks each wheel level, each passed slot and each chained
// entry touched, going through slot and entry memories with one write and one
// registered read port each and one shared 64-bit subtractor. Fired timers
// come out one per response transaction; the last response of a transaction
// carries last.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_timer_wheel
   import htw_pkg::*;
#(
   parameter int          NEAR_BITS    = 8,
   parameter int          FAR_BITS     = 6,
   parameter int          POOL_ENTRIES = 64,
   parameter logic [31:0] MAX_DELAY    = 32'hFFFF_FFFF
) (
   input  wire       clock,
   input  wire       reset,
   htw_req_if.sink   req,
   htw_rsp_if.source rsp
);

   localparam int NEAR_SIZE = 1 << NEAR_BITS;
   localparam int FAR_SIZE  = 1 << FAR_BITS;
   localparam int FAW       = FAR_BITS + 2;
   localparam int PW        = $clog2(POOL_ENTRIES + 1);
   localparam int IW        = $clog2(POOL_ENTRIES);
   localparam int SW        = (NEAR_BITS > FAR_BITS) ? NEAR_BITS : FAR_BITS;
   localparam int KW        = SW + 1;
   localparam int CLR_A     = (NEAR_SIZE > 4 * FAR_SIZE) ? NEAR_SIZE : 4 * FAR_SIZE;
   localparam int CLR_N     = (CLR_A > POOL_ENTRIES) ? CLR_A : POOL_ENTRIES;
   localparam int CLRW      = $clog2(CLR_N) + 1;
   localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

   // memories
   logic [PW-1:0]      nh_mem [NEAR_SIZE];
   logic [PW-1:0]      fh_mem [4*FAR_SIZE];
   logic [PW-1:0]      nx_mem [POOL_ENTRIES];
   logic [TIME_W-1:0]  ex_mem [POOL_ENTRIES];
   logic [TAG_W-1:0]   tg_mem [POOL_ENTRIES];
   logic               ac_mem [POOL_ENTRIES];

   logic               nh_we;
   logic [NEAR_BITS-1:0] nh_waddr, nh_raddr;
   logic [PW-1:0]      nh_wdata, nh_rd_ff;
   logic               fh_we;
   logic [FAW-1:0]     fh_waddr, fh_raddr;
   logic [PW-1:0]      fh_wdata, fh_rd_ff;
   logic               nx_we;
   logic [IW-1:0]      nx_waddr;
   logic [PW-1:0]      nx_wdata, nx_rd_ff;
   logic               ex_we;
   logic [TIME_W-1:0]  ex_wdata, ex_rd_ff;
   logic               tg_we;
   logic [TAG_W-1:0]   tg_wdata, tg_rd_ff;
   logic               ac_we;
   logic [IW-1:0]      ac_waddr, ent_waddr, ent_raddr;
   logic               ac_wdata, ac_rd_ff;

   // registers
   state_type          state_ff, state_in;
   logic [CLRW-1:0]    clr_ff, clr_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [TAG_W-1:0]   utag_ff, utag_in;
   logic [TIME_W-1:0]  last_time_ff, last_time_in;
   logic [PW-1:0]      free_head_ff, free_head_in;
   logic [PW-1:0]      cur_ff, cur_in;
   logic [PW-1:0]      nxt_ff, nxt_in;
   logic [PW-1:0]      prev_ff, prev_in;
   logic               lnk_far_ff, lnk_far_in;
   logic [NEAR_BITS-1:0] lnk_nidx_ff, lnk_nidx_in;
   logic [FAW-1:0]     lnk_fidx_ff, lnk_fidx_in;
   logic               ret_add_ff, ret_add_in;
   logic [1:0]         lv_ff, lv_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [KW-1:0]      n_ff, n_in;
   logic [SW-1:0]      start_ff, start_in;
   logic [NEAR_BITS-1:0] nslot_ff, nslot_in;
   logic [FAW-1:0]     fslot_ff, fslot_in;
   logic [TIME_W-1:0]  span_ff, span_in;
   logic [TIME_W-1:0]  diff_ff, diff_in;
   logic               borrow_ff, borrow_in;
   logic               act_ff, act_in;
   logic [TAG_W-1:0]   etag_ff, etag_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [PW-1:0]      pend_handle_ff, pend_handle_in;
   logic [TAG_W-1:0]   pend_tag_ff, pend_tag_in;
   kind_type           fin_kind_ff, fin_kind_in;
   logic [HANDLE_W-1:0] fin_handle_ff, fin_handle_in;
   logic [TAG_W-1:0]   fin_tag_ff, fin_tag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_last_ff, rsp_last_in;

   // shared subtractor
   logic [TIME_W-1:0]  sub_a, sub_b;
   logic [TIME_W:0]    sub_res;

   // helpers
   logic               req_acc, rsp_free;
   logic               add_zero, add_rej, adv_fwd;
   logic [TIME_W-1:0]  add_expire;
   logic [TIME_W-1:0]  pl_delay, pl_expire;
   logic               pl_ok, pl_far;
   logic [NEAR_BITS-1:0] pl_nidx;
   logic [FAW-1:0]     pl_fidx;
   logic               cas_full;
   logic [FAR_BITS-1:0] cas_begin, cas_end;
   logic               ch_due, ch_release, nr_due, nr_emit;
   logic [PW-1:0]      lnk_head;

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.handle    = rsp_handle_ff;
   assign rsp.fired_tag = rsp_tag_ff;
   assign rsp.last      = rsp_last_ff;

   assign req_acc    = req.valid && req.ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign add_zero   = (req.delay_ms == '0);
   assign add_rej    = (req.delay_ms > MAX_DELAY) || (free_head_ff == NIL);
   assign adv_fwd    = (req.now_ms > last_time_ff);
   assign add_expire = now_ff + TIME_W'(delay_ff);
   assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
   assign ch_due     = borrow_ff || (diff_ff == '0);
   assign ch_release = !act_ff || (!ch_due && !pl_ok);
   assign nr_due     = !sub_res[TIME_W];
   assign nr_emit    = act_ff && (count_ff < CNT_W'(MAX_RESULTS));
   assign lnk_head   = lnk_far_ff ? fh_rd_ff : nh_rd_ff;
   assign ent_raddr  = cur_ff[IW-1:0];

   always_comb begin
      case (state_ff)
         ST_CH_SUB: begin
            sub_a = ex_rd_ff;
            sub_b = now_ff;
         end
         ST_NR_CHK: begin
            sub_a = now_ff;
            sub_b = ex_rd_ff;
         end
         default: begin
            sub_a = now_ff;
            sub_b = last_time_ff;
         end
      endcase
   end

   // level and slot for a delay and expire time
   always_comb begin
      pl_delay  = (state_ff == ST_ADD_WR) ? TIME_W'(delay_ff) : diff_ff;
      pl_expire = (state_ff == ST_ADD_WR) ? add_expire : ex_rd_ff;
      pl_ok     = 1'b0;
      pl_far    = 1'b0;
      pl_nidx   = pl_expire[NEAR_BITS-1:0];
      pl_fidx   = '0;
      for (int l = 3; l >= 0; l--) begin
         if ((l < 3) ? ((pl_delay >> (NEAR_BITS + (l + 1) * FAR_BITS)) == '0)
                     : (pl_delay <= TIME_W'(MAX_DELAY))) begin
            pl_ok   = 1'b1;
            pl_far  = 1'b1;
            pl_fidx = {2'(l), pl_expire[NEAR_BITS + l * FAR_BITS +: FAR_BITS]};
         end
      end
      if (pl_delay < TIME_W'(NEAR_SIZE)) begin
         pl_ok  = 1'b1;
         pl_far = 1'b0;
      end
   end

   // passed-slot range of the current far level
   always_comb begin
      cas_full  = 1'b0;
      cas_begin = '0;
      cas_end   = '0;
      for (int l = 0; l < 4; l++) begin
         if (lv_ff == 2'(l)) begin
            cas_full  = (span_ff >> (NEAR_BITS + (l + 1) * FAR_BITS)) != '0;
            cas_begin = last_time_ff[NEAR_BITS + l * FAR_BITS +: FAR_BITS];
            cas_end   = now_ff[NEAR_BITS + l * FAR_BITS +: FAR_BITS];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLRW'(CLR_N - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (op_type'(req.op))
                  OP_ADD:     state_in = (add_zero || add_rej) ? ST_FIN : ST_ADD_RD;
                  OP_ADVANCE: state_in = adv_fwd ? ST_ADV_INIT : ST_FIN;
                  default:    state_in = ST_FIN;
               endcase
            end
         end
         ST_ADD_RD:    state_in = ST_ADD_WR;
         ST_ADD_WR:    state_in = ST_LNK_RD;
         ST_LNK_RD:    state_in = ST_LNK_WR;
         ST_LNK_WR: begin
            if (ret_add_ff)         state_in = ST_FIN;
            else if (nxt_ff == NIL) state_in = ST_CAS_SLOT;
            else                    state_in = ST_CH_RD;
         end
         ST_ADV_INIT:  state_in = ST_CAS_SETUP;
         ST_CAS_SETUP: state_in = ST_CAS_SLOT;
         ST_CAS_SLOT: begin
            if (k_ff != n_ff)       state_in = ST_CAS_HEAD;
            else if (lv_ff == 2'd0) state_in = ST_NR_SETUP;
            else                    state_in = ST_CAS_SETUP;
         end
         ST_CAS_HEAD:  state_in = (fh_rd_ff == NIL) ? ST_CAS_SLOT : ST_CH_RD;
         ST_CH_RD:     state_in = ST_CH_SUB;
         ST_CH_SUB:    state_in = ST_CH_DEC;
         ST_CH_DEC: begin
            if (!ch_release)        state_in = ST_LNK_RD;
            else if (nxt_ff == NIL) state_in = ST_CAS_SLOT;
            else                    state_in = ST_CH_RD;
         end
         ST_NR_SETUP:  state_in = ST_NR_SLOT;
         ST_NR_SLOT:   state_in = (k_ff == n_ff) ? ST_FIN : ST_NR_HEAD;
         ST_NR_HEAD:   state_in = (nh_rd_ff == NIL) ? ST_NR_SLOT : ST_NR_RD;
         ST_NR_RD:     state_in = ST_NR_CHK;
         ST_NR_CHK: begin
            if (nr_due)               state_in = ST_NR_REL;
            else if (nx_rd_ff == NIL) state_in = ST_NR_SLOT;
            else                      state_in = ST_NR_RD;
         end
         ST_NR_REL: begin
            if (nr_emit)            state_in = ST_NR_EMIT;
            else if (nxt_ff == NIL) state_in = ST_NR_SLOT;
            else                    state_in = ST_NR_RD;
         end
         ST_NR_EMIT: begin
            if (!pend_valid_ff || rsp_free)
               state_in = (nxt_ff == NIL) ? ST_NR_SLOT : ST_NR_RD;
         end
         ST_FIN: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      clr_in         = clr_ff;
      now_in         = now_ff;
      delay_in       = delay_ff;
      utag_in        = utag_ff;
      last_time_in   = last_time_ff;
      free_head_in   = free_head_ff;
      cur_in         = cur_ff;
      nxt_in         = nxt_ff;
      prev_in        = prev_ff;
      lnk_far_in     = lnk_far_ff;
      lnk_nidx_in    = lnk_nidx_ff;
      lnk_fidx_in    = lnk_fidx_ff;
      ret_add_in     = ret_add_ff;
      lv_in          = lv_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      start_in       = start_ff;
      nslot_in       = nslot_ff;
      fslot_in       = fslot_ff;
      span_in        = span_ff;
      diff_in        = diff_ff;
      borrow_in      = borrow_ff;
      act_in         = act_ff;
      etag_in        = etag_ff;
      count_in       = count_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      pend_tag_in    = pend_tag_ff;
      fin_kind_in    = fin_kind_ff;
      fin_handle_in  = fin_handle_ff;
      fin_tag_in     = fin_tag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_last_in    = rsp_last_ff;

      nh_we     = 1'b0;
      nh_waddr  = nslot_ff;
      nh_wdata  = NIL;
      nh_raddr  = lnk_nidx_ff;
      fh_we     = 1'b0;
      fh_waddr  = fslot_ff;
      fh_wdata  = NIL;
      fh_raddr  = lnk_fidx_ff;
      nx_we     = 1'b0;
      nx_waddr  = cur_ff[IW-1:0];
      nx_wdata  = free_head_ff;
      ex_we     = 1'b0;
      ex_wdata  = add_expire;
      tg_we     = 1'b0;
      tg_wdata  = utag_ff;
      ac_we     = 1'b0;
      ac_waddr  = cur_ff[IW-1:0];
      ac_wdata  = 1'b1;
      ent_waddr = cur_ff[IW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            clr_in   = clr_ff + CLRW'(1);
            nh_we    = clr_ff < CLRW'(NEAR_SIZE);
            nh_waddr = clr_ff[NEAR_BITS-1:0];
            fh_we    = clr_ff < CLRW'(4 * FAR_SIZE);
            fh_waddr = clr_ff[FAW-1:0];
            nx_we    = clr_ff < CLRW'(POOL_ENTRIES);
            nx_waddr = clr_ff[IW-1:0];
            nx_wdata = PW'(clr_ff + CLRW'(1));
            ac_we    = nx_we;
            ac_waddr = clr_ff[IW-1:0];
            ac_wdata = 1'b0;
         end
         ST_IDLE: begin
            if (req_acc) begin
               now_in        = req.now_ms;
               delay_in      = req.delay_ms;
               utag_in       = req.user_tag;
               cur_in        = free_head_ff;
               fin_kind_in   = KIND_DONE;
               fin_handle_in = '0;
               fin_tag_in    = '0;
               pend_valid_in = 1'b0;
               count_in      = '0;
               case (op_type'(req.op))
                  OP_ADD: begin
                     if (add_zero) begin
                        fin_kind_in = KIND_FIRED;
                        fin_tag_in  = req.user_tag;
                     end else if (add_rej) begin
                        fin_kind_in = KIND_REJECTED;
                     end
                  end
                  OP_CANCEL: begin
                     ac_we    = 32'(req.cancel_handle) < 32'(POOL_ENTRIES);
                     ac_waddr = IW'(req.cancel_handle);
                     ac_wdata = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            free_head_in  = nx_rd_ff;
            ex_we         = 1'b1;
            tg_we         = 1'b1;
            ac_we         = 1'b1;
            lnk_far_in    = pl_far;
            lnk_nidx_in   = pl_nidx;
            lnk_fidx_in   = pl_fidx;
            ret_add_in    = 1'b1;
            fin_kind_in   = KIND_ADDED;
            fin_handle_in = HANDLE_W'(cur_ff);
         end
         ST_LNK_WR: begin
            nx_we    = 1'b1;
            nx_wdata = lnk_head;
            nh_we    = !lnk_far_ff;
            nh_waddr = lnk_nidx_ff;
            nh_wdata = cur_ff;
            fh_we    = lnk_far_ff;
            fh_waddr = lnk_fidx_ff;
            fh_wdata = cur_ff;
            if (!ret_add_ff) cur_in = nxt_ff;
         end
         ST_ADV_INIT: begin
            span_in = sub_res[TIME_W-1:0];
            lv_in   = 2'd3;
         end
         ST_CAS_SETUP: begin
            k_in     = '0;
            n_in     = cas_full ? KW'(FAR_SIZE) : KW'(FAR_BITS'(cas_end - cas_begin));
            start_in = cas_full ? '0 : SW'(FAR_BITS'(cas_begin + FAR_BITS'(1)));
         end
         ST_CAS_SLOT: begin
            fh_raddr = {lv_ff, FAR_BITS'(start_ff + SW'(k_ff))};
            fslot_in = fh_raddr;
            if (k_ff != n_ff) k_in = k_ff + KW'(1);
            else if (lv_ff != 2'd0) lv_in = lv_ff - 2'd1;
         end
         ST_CAS_HEAD: begin
            fh_we  = 1'b1;
            cur_in = fh_rd_ff;
         end
         ST_CH_SUB: begin
            diff_in   = sub_res[TIME_W-1:0];
            borrow_in = sub_res[TIME_W];
            act_in    = ac_rd_ff;
            nxt_in    = nx_rd_ff;
         end
         ST_CH_DEC: begin
            ret_add_in = 1'b0;
            if (ch_release) begin
               nx_we        = 1'b1;
               free_head_in = cur_ff;
               cur_in       = nxt_ff;
            end else if (ch_due) begin
               lnk_far_in  = 1'b0;
               lnk_nidx_in = now_ff[NEAR_BITS-1:0];
            end else begin
               lnk_far_in  = pl_far;
               lnk_nidx_in = pl_nidx;
               lnk_fidx_in = pl_fidx;
            end
         end
         ST_NR_SETUP: begin
            k_in = '0;
            if (span_ff[TIME_W-1:NEAR_BITS] != '0) begin
               n_in     = KW'(NEAR_SIZE);
               start_in = '0;
            end else begin
               n_in     = KW'(NEAR_BITS'(now_ff[NEAR_BITS-1:0]
                                         - last_time_ff[NEAR_BITS-1:0]));
               start_in = SW'(NEAR_BITS'(last_time_ff[NEAR_BITS-1:0]
                                         + NEAR_BITS'(1)));
            end
         end
         ST_NR_SLOT: begin
            nh_raddr = NEAR_BITS'(start_ff + SW'(k_ff));
            nslot_in = nh_raddr;
            prev_in  = NIL;
            if (k_ff != n_ff) k_in = k_ff + KW'(1);
            else last_time_in = now_ff;
         end
         ST_NR_HEAD: begin
            cur_in = nh_rd_ff;
         end
         ST_NR_CHK: begin
            nxt_in  = nx_rd_ff;
            act_in  = ac_rd_ff;
            etag_in = tg_rd_ff;
            if (nr_due) begin
               if (prev_ff == NIL) begin
                  nh_we    = 1'b1;
                  nh_wdata = nx_rd_ff;
               end else begin
                  nx_we    = 1'b1;
                  nx_waddr = prev_ff[IW-1:0];
                  nx_wdata = nx_rd_ff;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = nx_rd_ff;
            end
         end
         ST_NR_REL: begin
            nx_we        = 1'b1;
            free_head_in = cur_ff;
            if (!nr_emit) cur_in = nxt_ff;
         end
         ST_NR_EMIT: begin
            if (!pend_valid_ff || rsp_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_FIRED;
                  rsp_handle_in = HANDLE_W'(pend_handle_ff);
                  rsp_tag_in    = pend_tag_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in  = 1'b1;
               pend_handle_in = cur_ff;
               pend_tag_in    = etag_ff;
               count_in       = count_ff + CNT_W'(1);
               cur_in         = nxt_ff;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  rsp_kind_in   = KIND_FIRED;
                  rsp_handle_in = HANDLE_W'(pend_handle_ff);
                  rsp_tag_in    = pend_tag_ff;
               end else begin
                  rsp_kind_in   = fin_kind_ff;
                  rsp_handle_in = fin_handle_ff;
                  rsp_tag_in    = fin_tag_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (nh_we) nh_mem[nh_waddr] <= nh_wdata;
      nh_rd_ff <= nh_mem[nh_raddr];
      if (fh_we) fh_mem[fh_waddr] <= fh_wdata;
      fh_rd_ff <= fh_mem[fh_raddr];
   end

   always_ff @(posedge clock) begin
      if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
      nx_rd_ff <= nx_mem[ent_raddr];
      if (ex_we) ex_mem[ent_waddr] <= ex_wdata;
      ex_rd_ff <= ex_mem[ent_raddr];
      if (tg_we) tg_mem[ent_waddr] <= tg_wdata;
      tg_rd_ff <= tg_mem[ent_raddr];
      if (ac_we) ac_mem[ac_waddr] <= ac_wdata;
      ac_rd_ff <= ac_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         last_time_ff  <= '0;
         free_head_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         last_time_ff  <= last_time_in;
         free_head_ff  <= free_head_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      delay_ff       <= delay_in;
      utag_ff        <= utag_in;
      cur_ff         <= cur_in;
      nxt_ff         <= nxt_in;
      prev_ff        <= prev_in;
      lnk_far_ff     <= lnk_far_in;
      lnk_nidx_ff    <= lnk_nidx_in;
      lnk_fidx_ff    <= lnk_fidx_in;
      ret_add_ff     <= ret_add_in;
      lv_ff          <= lv_in;
      k_ff           <= k_in;
      n_ff           <= n_in;
      start_ff       <= start_in;
      nslot_ff       <= nslot_in;
      fslot_ff       <= fslot_in;
      span_ff        <= span_in;
      diff_ff        <= diff_in;
      borrow_ff      <= borrow_in;
      act_ff         <= act_in;
      etag_ff        <= etag_in;
      count_ff       <= count_in;
      pend_handle_ff <= pend_handle_in;
      pend_tag_ff    <= pend_tag_in;
      fin_kind_ff    <= fin_kind_in;
      fin_handle_ff  <= fin_handle_in;
      fin_tag_ff     <= fin_tag_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ----- rtl/htw_checker.sv -----
// ----------------------------------------------------------------------------
// htw_checker
// port-level checks of the timer wheel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module htw_checker
   import htw_pkg::*;
(
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire [KIND_W-1:0]   rsp_kind,
   input wire [HANDLE_W-1:0] rsp_handle,
   input wire [TAG_W-1:0]    rsp_fired_tag,
   input wire                rsp_last
);

   // one transaction in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous transaction busy");

   // no new request before the final response
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("ready while fired responses still pending");

   a_single_kinds_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_FIRED) |-> rsp_last)
      else $error("non-fire response without last");

   a_plain_kinds_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_REJECTED || rsp_kind == KIND_DONE))
         |-> (rsp_handle == '0 && rsp_fired_tag == '0))
      else $error("reject or done response carries handle or tag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)
                                     && $stable(rsp_handle) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_kind     (rsp.kind),
   .rsp_handle   (rsp.handle),
   .rsp_fired_tag(rsp.fired_tag),
   .rsp_last     (rsp.last)
);

`default_nettype wire
